// ===== rtl/stl_pkg.sv =====
// Shared types, codes and character classes for the Scheme token lexer.
package stl_pkg;

    // Position counter width and the width of the reported start position
    localparam int PosBits   = 16;
    localparam int StartBits = 16;

    typedef logic [PosBits-1:0]   pos_t;
    typedef logic [StartBits-1:0] start_t;

    // Event codes
    localparam logic [1:0] EV_VALUE = 2'd0;
    localparam logic [1:0] EV_DONE  = 2'd1;
    localparam logic [1:0] EV_BAD   = 2'd2;

    // Token kinds
    localparam logic [2:0] K_IDENT    = 3'd0;
    localparam logic [2:0] K_STRING   = 3'd1;
    localparam logic [2:0] K_LPAREN   = 3'd2;
    localparam logic [2:0] K_RPAREN   = 3'd3;
    localparam logic [2:0] K_QUOTE    = 3'd4;
    localparam logic [2:0] K_BACKTICK = 3'd5;
    localparam logic [2:0] K_COMMA    = 3'd6;
    localparam logic [2:0] K_ERROR    = 3'd7;

    // Characters the lexer looks for
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_BTICK  = 8'h60;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_TILDE  = 8'h7E;

    // One result item
    typedef struct packed {
        logic [1:0] ev;
        logic [2:0] kind;
        start_t     start;
        logic [7:0] ch;
    } result_t;

    // All results caused by one input byte
    localparam int MaxResults = 3;
    typedef logic [1:0] count_t;

    typedef struct packed {
        count_t                      count;
        result_t [MaxResults-1:0]    res;
    } bundle_t;

    // Queue between front and back
    localparam int QueueDepth = 4;
    localparam int QPtrBits   = $clog2(QueueDepth);
    typedef logic [QPtrBits-1:0] qptr_t;
    typedef logic [QPtrBits:0]   qcount_t;

    function automatic logic is_initial(input logic [7:0] c);
        return (c inside {[8'h61:8'h7A], [8'h41:8'h5A]}) ||
               (c inside {8'h21, 8'h24, 8'h25, 8'h26, 8'h2A, 8'h2F, 8'h3A, 8'h3C,
                          8'h3D, 8'h3E, 8'h3F, 8'h5E, 8'h5F, CH_TILDE});
    endfunction

    function automatic logic is_subsequent(input logic [7:0] c);
        return is_initial(c) || (c inside {[8'h30:8'h39]}) ||
               (c inside {CH_PLUS, CH_MINUS, CH_DOT, CH_AT});
    endfunction

    function automatic start_t to_start(input pos_t p);
        return StartBits'(p);
    endfunction

    function automatic result_t make_res(input logic [1:0] ev, input logic [2:0] kind,
                                         input pos_t p, input logic [7:0] ch);
        result_t r;
        r.ev    = ev;
        r.kind  = kind;
        r.start = to_start(p);
        r.ch    = ch;
        return r;
    endfunction

endpackage

// ===== rtl/stl_front.sv =====
// Front end: accepts bytes, runs the lexer mode machine and builds result bundles.
module stl_front
    import stl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    input  logic       queue_full,
    output logic       push,
    output bundle_t    push_data
);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_COMMENT,
        MODE_IDENT,
        MODE_BAR,
        MODE_STRING
    } mode_t;

    mode_t   mode_reg, mode_next;
    pos_t    tok_reg, tok_next;
    pos_t    pos_reg, pos_next;

    logic    in_fire;
    logic    do_idle;
    count_t  n;
    result_t [MaxResults-1:0] res;

    assign in_ready = !queue_full;
    assign in_fire  = in_valid && in_ready;

    // Next mode and the results for the current byte
    always_comb
    begin
        mode_next = mode_reg;
        tok_next  = tok_reg;
        do_idle   = 1'b0;
        n         = '0;
        res       = '0;

        case (mode_reg)
            MODE_COMMENT:
            begin
                if (text_byte == CH_LF || text_byte == CH_NUL)
                begin
                    do_idle = 1'b1;
                end
            end
            MODE_IDENT:
            begin
                if (is_subsequent(text_byte))
                begin
                    res[n] = make_res(EV_VALUE, K_IDENT, tok_reg, text_byte);
                    n      = n + 2'd1;
                end
                else
                begin
                    res[n] = make_res(EV_DONE, K_IDENT, tok_reg, 8'h00);
                    n      = n + 2'd1;
                    do_idle = 1'b1;
                end
            end
            MODE_BAR:
            begin
                if (text_byte == CH_BAR)
                begin
                    res[n] = make_res(EV_VALUE, K_IDENT, tok_reg, text_byte);
                    n      = n + 2'd1;
                    res[n] = make_res(EV_DONE, K_IDENT, tok_reg, 8'h00);
                    n      = n + 2'd1;
                    mode_next = MODE_IDLE;
                end
                else if (text_byte == CH_BSLASH)
                begin
                    res[n] = make_res(EV_DONE, K_ERROR, tok_reg, 8'h00);
                    n      = n + 2'd1;
                    do_idle = 1'b1;
                end
                else
                begin
                    res[n] = make_res(EV_VALUE, K_IDENT, tok_reg, text_byte);
                    n      = n + 2'd1;
                end
            end
            MODE_STRING:
            begin
                if (text_byte == CH_DQUOTE)
                begin
                    res[n] = make_res(EV_DONE, K_STRING, tok_reg, 8'h00);
                    n      = n + 2'd1;
                    mode_next = MODE_IDLE;
                end
                else if (text_byte == CH_BSLASH)
                begin
                    res[n] = make_res(EV_DONE, K_ERROR, tok_reg, 8'h00);
                    n      = n + 2'd1;
                    do_idle = 1'b1;
                end
                else
                begin
                    res[n] = make_res(EV_VALUE, K_STRING, tok_reg, text_byte);
                    n      = n + 2'd1;
                end
            end
            default:
            begin
                do_idle = 1'b1;
            end
        endcase

        // Byte handled as in idle
        if (do_idle)
        begin
            mode_next = MODE_IDLE;
            if (text_byte inside {CH_SPACE, CH_TAB, CH_LF, CH_CR})
            begin
                mode_next = MODE_IDLE;
            end
            else if (text_byte == CH_SEMI)
            begin
                mode_next = MODE_COMMENT;
            end
            else if (is_initial(text_byte))
            begin
                tok_next  = pos_reg;
                mode_next = MODE_IDENT;
                res[n] = make_res(EV_VALUE, K_IDENT, pos_reg, text_byte);
                n      = n + 2'd1;
            end
            else if (text_byte == CH_BAR)
            begin
                tok_next  = pos_reg;
                mode_next = MODE_BAR;
                res[n] = make_res(EV_VALUE, K_IDENT, pos_reg, text_byte);
                n      = n + 2'd1;
            end
            else if (text_byte inside {CH_PLUS, CH_MINUS, CH_DOT})
            begin
                res[n] = make_res(EV_DONE, K_ERROR, pos_reg, 8'h00);
                n      = n + 2'd1;
            end
            else if (text_byte == CH_DQUOTE)
            begin
                tok_next  = pos_reg;
                mode_next = MODE_STRING;
            end
            else if (text_byte == CH_LPAREN)
            begin
                res[n] = make_res(EV_DONE, K_LPAREN, pos_reg, 8'h00);
                n      = n + 2'd1;
            end
            else if (text_byte == CH_RPAREN)
            begin
                res[n] = make_res(EV_DONE, K_RPAREN, pos_reg, 8'h00);
                n      = n + 2'd1;
            end
            else if (text_byte == CH_APOS)
            begin
                res[n] = make_res(EV_DONE, K_QUOTE, pos_reg, 8'h00);
                n      = n + 2'd1;
            end
            else if (text_byte == CH_BTICK)
            begin
                res[n] = make_res(EV_DONE, K_BACKTICK, pos_reg, 8'h00);
                n      = n + 2'd1;
            end
            else if (text_byte == CH_COMMA)
            begin
                res[n] = make_res(EV_DONE, K_COMMA, pos_reg, 8'h00);
                n      = n + 2'd1;
            end
            else
            begin
                res[n] = make_res(EV_BAD, K_ERROR, pos_reg, text_byte);
                n      = n + 2'd1;
            end
        end

        // End of text closes any open token and rewinds the position
        if (end_of_text)
        begin
            if (mode_next == MODE_IDENT)
            begin
                res[n] = make_res(EV_DONE, K_IDENT, tok_next, 8'h00);
                n      = n + 2'd1;
            end
            else if (mode_next == MODE_BAR || mode_next == MODE_STRING)
            begin
                res[n] = make_res(EV_DONE, K_ERROR, tok_next, 8'h00);
                n      = n + 2'd1;
            end
            mode_next = MODE_IDLE;
            pos_next  = '0;
        end
        else
        begin
            pos_next = pos_reg + pos_t'(1);
        end
    end

    assign push            = in_fire && (n != '0);
    assign push_data.count = n;
    assign push_data.res   = res;

    // Lexer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            tok_reg  <= '0;
            pos_reg  <= '0;
        end
        else if (in_fire)
        begin
            mode_reg <= mode_next;
            tok_reg  <= tok_next;
            pos_reg  <= pos_next;
        end
    end

endmodule

// ===== rtl/stl_queue.sv =====
// Short bundle queue between the lexer front end and the result sequencer.
module stl_queue
    import stl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t push_data,
    input  logic    pop,
    output bundle_t head,
    output logic    empty,
    output logic    full
);

    bundle_t mem [QueueDepth];
    qptr_t   wr_ptr_reg;
    qptr_t   rd_ptr_reg;
    qcount_t count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == qcount_t'(QueueDepth));
    assign head  = mem[rd_ptr_reg];

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + qptr_t'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + qptr_t'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + qcount_t'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - qcount_t'(1);
            end
        end
    end

endmodule

// ===== rtl/stl_back.sv =====
// Back end: hands out the results of each bundle one per request.
module stl_back
    import stl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  bundle_t    head,
    input  logic       empty,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] event_res,
    output logic [2:0] token_kind,
    output start_t     start_position,
    output logic [7:0] value_char,
    output logic       last_result
);

    count_t  idx_reg;
    result_t cur;
    logic    is_last;
    logic    out_fire;

    assign cur      = head.res[idx_reg];
    assign is_last  = (idx_reg == head.count - 2'd1);
    assign out_valid = !empty;
    assign out_fire = out_valid && out_ready;
    assign pop      = out_fire && is_last;

    assign event_res      = cur.ev;
    assign token_kind     = cur.kind;
    assign start_position = cur.start;
    assign value_char     = cur.ch;
    assign last_result    = is_last;

    // Position within the head bundle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (out_fire)
        begin
            idx_reg <= is_last ? count_t'(0) : idx_reg + 2'd1;
        end
    end

endmodule

// ===== rtl/scheme_token_lexer_top.sv =====
// Top level of the Scheme token lexer.
//
// Input channel (in_valid/in_ready): one request per source byte, text_byte
// plus end_of_text marking the last byte of a text. Output channel
// (out_valid/out_ready): one request per result item; last_result marks the
// final result caused by a byte. Bytes that cause no result produce nothing.
//
// The front end accepts one byte per cycle while the queue is not full and
// resolves the lexer mode in the same cycle; its results (zero to three) go
// as one bundle into a four-entry queue, which registers them. The back end
// emits one result per cycle from the queue head while out_ready is high.
// Throughput is one byte per cycle while bytes average at most one result;
// a byte with k results holds the queue head until all k have been taken.
//
// Reset puts the lexer in idle at position zero and empties the queue.
// When the receiver stalls, the current result holds on the outputs; the
// front keeps taking bytes until the queue fills, then drops in_ready.
module scheme_token_lexer_top
    import stl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  text_byte,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  event_res,
    output logic [2:0]  token_kind,
    output logic [15:0] start_position,
    output logic [7:0]  value_char,
    output logic        last_result
);

    logic    push;
    bundle_t push_data;
    logic    pop;
    bundle_t head;
    logic    empty;
    logic    full;

    stl_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .queue_full  (full),
        .push        (push),
        .push_data   (push_data)
    );

    stl_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    stl_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .empty          (empty),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .event_res      (event_res),
        .token_kind     (token_kind),
        .start_position (start_position),
        .value_char     (value_char),
        .last_result    (last_result)
    );

endmodule

// ===== verif/scheme_token_lexer_top_tb.sv =====
// Self-checking testbench for the Scheme token lexer: byte stream in, lexer results compared.
`timescale 1ns / 1ps

module scheme_token_lexer_top_tb
    import stl_pkg::*;
();

    localparam int CycleLimit  = 50000;
    localparam int HoldCycles  = 80;
    localparam int RandomBytes = 152;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_COMMENT,
        SCAN_SYMBOL,
        SCAN_BAR,
        SCAN_STRING
    } scan_mode_t;

    typedef struct {
        result_t tok;
        logic    last;
    } lexer_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  text_byte;
    logic        end_of_text;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  event_res;
    logic [2:0]  token_kind;
    logic [15:0] start_position;
    logic [7:0]  value_char;
    logic        last_result;

    // Lexer state mirrored on the testbench side
    scan_mode_t scan_mode;
    pos_t       scan_pos;
    pos_t       tok_start;
    result_t    byte_results[$];
    lexer_result_t lexer_results[$];

    int send_idle_pct;
    int stall_pct;
    bit hold_output;
    int cycle_count;
    int bytes_sent;
    int results_seen;
    int failures;

    string symbol_head = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ!$%&*/:<=>?^_~";
    string symbol_tail = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789+-.@";
    string punct_set   = "()'`,";
    string sign_set    = "+-.";
    string blank_set   = " \t\n\r";

    scheme_token_lexer_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .text_byte      (text_byte),
        .end_of_text    (end_of_text),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .event_res      (event_res),
        .token_kind     (token_kind),
        .start_position (start_position),
        .value_char     (value_char),
        .last_result    (last_result)
    );

    // 50 MHz clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ---------------------------------------------------------------
    // Character classes
    // ---------------------------------------------------------------
    function automatic bit starts_symbol(input logic [7:0] c);
        return (c inside {["a":"z"], ["A":"Z"]}) ||
               (c inside {"!", "$", "%", "&", "*", "/", ":", "<", "=", ">", "?", "^", "_",
                          CH_TILDE});
    endfunction

    function automatic bit continues_symbol(input logic [7:0] c);
        return starts_symbol(c) || (c inside {["0":"9"]}) ||
               (c inside {CH_PLUS, CH_MINUS, CH_DOT, CH_AT});
    endfunction

    function automatic void add_result(input logic [1:0] ev, input logic [2:0] kind,
                                       input pos_t st, input logic [7:0] ch);
        result_t r;
        r.ev    = ev;
        r.kind  = kind;
        r.start = st;
        r.ch    = ch;
        byte_results.push_back(r);
    endfunction

    // A byte seen while no token is open
    function automatic void scan_idle_byte(input logic [7:0] c, input pos_t p);
        if (c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR})
            return;
        if (c == CH_SEMI)
            scan_mode = SCAN_COMMENT;
        else if (starts_symbol(c))
        begin
            tok_start = p;
            scan_mode = SCAN_SYMBOL;
            add_result(EV_VALUE, K_IDENT, p, c);
        end
        else if (c == CH_BAR)
        begin
            tok_start = p;
            scan_mode = SCAN_BAR;
            add_result(EV_VALUE, K_IDENT, p, c);
        end
        else if (c inside {CH_PLUS, CH_MINUS, CH_DOT})
            add_result(EV_DONE, K_ERROR, p, CH_NUL);
        else if (c == CH_DQUOTE)
        begin
            tok_start = p;
            scan_mode = SCAN_STRING;
        end
        else if (c == CH_LPAREN)
            add_result(EV_DONE, K_LPAREN, p, CH_NUL);
        else if (c == CH_RPAREN)
            add_result(EV_DONE, K_RPAREN, p, CH_NUL);
        else if (c == CH_APOS)
            add_result(EV_DONE, K_QUOTE, p, CH_NUL);
        else if (c == CH_BTICK)
            add_result(EV_DONE, K_BACKTICK, p, CH_NUL);
        else if (c == CH_COMMA)
            add_result(EV_DONE, K_COMMA, p, CH_NUL);
        else
            add_result(EV_BAD, K_ERROR, p, c);
    endfunction

    // Advance the mirrored lexer by one accepted byte and queue its results
    function automatic void lex_byte(input logic [7:0] c, input logic eot);
        pos_t p;
        lexer_result_t item;
        p = scan_pos;
        byte_results.delete();
        case (scan_mode)
            SCAN_COMMENT:
            begin
                if (c == CH_LF || c == CH_NUL)
                begin
                    scan_mode = SCAN_IDLE;
                    scan_idle_byte(c, p);
                end
            end
            SCAN_SYMBOL:
            begin
                if (continues_symbol(c))
                    add_result(EV_VALUE, K_IDENT, tok_start, c);
                else
                begin
                    add_result(EV_DONE, K_IDENT, tok_start, CH_NUL);
                    scan_mode = SCAN_IDLE;
                    scan_idle_byte(c, p);
                end
            end
            SCAN_BAR:
            begin
                if (c == CH_BAR)
                begin
                    add_result(EV_VALUE, K_IDENT, tok_start, c);
                    add_result(EV_DONE, K_IDENT, tok_start, CH_NUL);
                    scan_mode = SCAN_IDLE;
                end
                else if (c == CH_BSLASH)
                begin
                    add_result(EV_DONE, K_ERROR, tok_start, CH_NUL);
                    scan_mode = SCAN_IDLE;
                    scan_idle_byte(c, p);
                end
                else
                    add_result(EV_VALUE, K_IDENT, tok_start, c);
            end
            SCAN_STRING:
            begin
                if (c == CH_DQUOTE)
                begin
                    add_result(EV_DONE, K_STRING, tok_start, CH_NUL);
                    scan_mode = SCAN_IDLE;
                end
                else if (c == CH_BSLASH)
                begin
                    add_result(EV_DONE, K_ERROR, tok_start, CH_NUL);
                    scan_mode = SCAN_IDLE;
                    scan_idle_byte(c, p);
                end
                else
                    add_result(EV_VALUE, K_STRING, tok_start, c);
            end
            default:
            begin
                scan_mode = SCAN_IDLE;
                scan_idle_byte(c, p);
            end
        endcase

        // End of text closes whatever is open and restarts the position count
        if (eot)
        begin
            if (scan_mode == SCAN_SYMBOL)
                add_result(EV_DONE, K_IDENT, tok_start, CH_NUL);
            else if (scan_mode == SCAN_BAR || scan_mode == SCAN_STRING)
                add_result(EV_DONE, K_ERROR, tok_start, CH_NUL);
            scan_mode = SCAN_IDLE;
            scan_pos  = '0;
        end
        else
            scan_pos = p + 1'b1;

        foreach (byte_results[i])
        begin
            item.tok  = byte_results[i];
            item.last = (i == byte_results.size() - 1);
            lexer_results.push_back(item);
        end
    endfunction

    // ---------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic eot);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        text_byte   <= b;
        end_of_text <= eot;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        lex_byte(b, eot);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_string(input string s, input logic eot_at_end);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eot_at_end && (i == s.len() - 1));
    endtask

    // Random text byte, now and then marking the end of the text
    task automatic send_text_byte(input logic [7:0] b);
        send_byte(b, $urandom_range(29) == 0);
    endtask

    // ---------------------------------------------------------------
    // Result side: random stalls, plus a forced hold-off
    // ---------------------------------------------------------------
    always @(negedge clk)
        out_ready <= !hold_output && ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        lexer_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (lexer_results.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: ev=%0d kind=%0d start=%0d ch=%02h last=%0b",
                             event_res, token_kind, start_position, value_char, last_result);
            end
            else
            begin
                want = lexer_results.pop_front();
                if (event_res !== want.tok.ev || token_kind !== want.tok.kind ||
                    start_position !== want.tok.start || value_char !== want.tok.ch ||
                    last_result !== want.last)
                begin
                    failures++;
                    if (failures <= 10)
                    begin
                        $display("mismatch on result %0d: expected ev=%0d kind=%0d start=%0d ch=%02h last=%0b",
                                 results_seen, want.tok.ev, want.tok.kind, want.tok.start,
                                 want.tok.ch, want.last);
                        $display("    got ev=%0d kind=%0d start=%0d ch=%02h last=%0b",
                                 event_res, token_kind, start_position, value_char,
                                 last_result);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     lexer_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Single-character tokens and the sign/dot error
    task automatic test_punctuation();
        send_string("()'`,+-.", 1'b0);
    endtask

    // Plain symbol ended by a character that cannot continue it
    task automatic test_symbols();
        send_string("a@)", 1'b0);
    endtask

    // Bar symbol closed normally, then one broken by a backslash
    task automatic test_bar_symbols();
        send_string("|x|", 1'b0);
        send_string("|\\", 1'b0);
    endtask

    task automatic test_strings();
        send_string("\"z\"", 1'b0);
        send_string("\"\\", 1'b0);
    endtask

    // Comment ended by newline, then one ended by NUL (NUL is then invalid)
    task automatic test_comments();
        send_string(";\n;", 1'b0);
        send_byte(CH_NUL, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    // End of text with a symbol, a bar symbol and a string still open
    task automatic test_end_of_text();
        send_byte("b", 1'b0);
        send_byte(CH_BAR, 1'b1);
        send_byte(CH_DQUOTE, 1'b1);
        send_byte("c", 1'b1);
    endtask

    // Receiver holds off while requests keep coming, so the input stalls
    task automatic test_backpressure();
        fork
            begin
                hold_output = 1'b1;
                repeat (HoldCycles)
                    @(negedge clk);
                hold_output = 1'b0;
            end
            begin
                repeat (12)
                    send_string("a(", 1'b0);
            end
        join
    endtask

    // One random lexeme, mostly well formed
    task automatic send_random_lexeme();
        int pick;
        int body;
        logic [7:0] c;
        pick = $urandom_range(99);
        body = $urandom_range(5);
        if (pick < 25)
        begin
            send_text_byte(symbol_head[$urandom_range(symbol_head.len() - 1)]);
            repeat (body)
                send_text_byte(symbol_tail[$urandom_range(symbol_tail.len() - 1)]);
            send_text_byte(punct_set[$urandom_range(punct_set.len() - 1)]);
        end
        else if (pick < 38 || pick < 51)
        begin
            // bar symbol or string with random content
            send_text_byte(pick < 38 ? CH_BAR : CH_DQUOTE);
            repeat (body)
            begin
                do
                    c = 8'($urandom_range(255));
                while (c == CH_BAR || c == CH_DQUOTE || c == CH_BSLASH);
                send_text_byte(c);
            end
            if ($urandom_range(5) == 0)
                send_text_byte(CH_BSLASH);
            else
                send_text_byte(pick < 38 ? CH_BAR : CH_DQUOTE);
        end
        else if (pick < 70)
            send_text_byte(punct_set[$urandom_range(punct_set.len() - 1)]);
        else if (pick < 77)
            send_text_byte(blank_set[$urandom_range(blank_set.len() - 1)]);
        else if (pick < 84)
        begin
            send_text_byte(CH_SEMI);
            repeat (body)
            begin
                do
                    c = 8'($urandom_range(255));
                while (c == CH_LF || c == CH_NUL);
                send_text_byte(c);
            end
            send_text_byte($urandom_range(1) ? CH_LF : CH_NUL);
        end
        else if (pick < 90)
            send_text_byte(sign_set[$urandom_range(sign_set.len() - 1)]);
        else
            send_text_byte(8'($urandom_range(255)));
    endtask

    // Random text under four idling patterns
    task automatic test_random_text();
        int idle_by_phase[4];
        int stall_by_phase[4];
        int goal;
        idle_by_phase  = '{0, 76, 0, 31};
        stall_by_phase = '{0, 0, 76, 31};
        goal = bytes_sent;
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = idle_by_phase[ph];
            stall_pct     = stall_by_phase[ph];
            goal += RandomBytes / 4;
            while (bytes_sent < goal)
                send_random_lexeme();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        text_byte     = '0;
        end_of_text   = 1'b0;
        out_ready     = 1'b0;
        hold_output   = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        cycle_count   = 0;
        bytes_sent    = 0;
        results_seen  = 0;
        failures      = 0;
        scan_mode     = SCAN_IDLE;
        scan_pos      = '0;
        tok_start     = '0;

        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_punctuation();
        test_symbols();
        test_bar_symbols();
        test_strings();
        test_comments();
        test_end_of_text();
        send_idle_pct = 31;
        stall_pct     = 31;
        test_backpressure();
        test_random_text();

        // Drain
        in_valid <= 1'b0;
        while (lexer_results.size() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);

        $display("lexer run: %0d bytes accepted, %0d results checked, %0d failures",
                 bytes_sent, results_seen, failures);
        $display("covered punctuation, symbols, bar symbols, strings, comments, end of text,");
        $display("output hold-off and random text under idle and stall patterns");
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/stl_pkg.sv
rtl/stl_front.sv
rtl/stl_queue.sv
rtl/stl_back.sv
rtl/scheme_token_lexer_top.sv
verif/scheme_token_lexer_top_tb.sv
